FILE: design/lpcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_pkg: shared types and constants for the linear probe cell map
// Field widths, the action codes and the controller/datapath words.
// ----------------------------------------------------------------------------
package lpcm_pkg;

   localparam int KEY_W            = 30;
   localparam int VALUE_W          = 48;
   localparam int RECORD_W         = 20;
   localparam int TB_W             = 4;
   localparam int MIN_SLOT_BITS    = 10;
   localparam int RESET_TABLE_BITS = 10;

   // golden-ratio hashing multiplier
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } act_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word
      logic hash;       // probe pointer to home slot, count to zero
      logic step;       // probe pointer to next slot with wrap
      logic clr_start;  // sweep pointer to slot zero
      logic clr_write;  // empty slot at sweep pointer, advance
      logic ins_key;    // write key entry at probe pointer
      logic ins_data;   // write value and record at probe pointer
      logic rsp_fire;   // register a result word
      logic rsp_hit;
      logic rsp_data;   // return stored value and record
      logic rsp_full;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      act_type act;
      logic    empty;       // slot read back is empty
      logic    match;       // slot read back holds the key
      logic    last_probe;  // probe count has covered the table in use
      logic    sweep_last;  // sweep pointer at the last slot
   } ctl_sts_type;

endpackage

FILE: design/linear_probe_cell_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_cell_map_unit: open-addressing cell map with linear probing
// Maps a packed cell key to an appearance word and a record index.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  request   | start in, busy out         | req_action, req_key, req_value_in,
//            |                            | req_record_in
//  response  | rsp_valid, one-cycle pulse | rsp_hit, rsp_value_out,
//            |                            | rsp_record_out, rsp_table_full
//  csr       | csr_write_en               | csr_write_data (table_bits)
//
// Lookup and insert: the word is loaded, dispatched and hashed to a home slot;
// each probe is one store read plus a compare; the result word is registered.
// Clear: all 2^MAX_SLOT_BITS slots are emptied, one slot per cycle.
// After reset busy stays high for a clearing pass over all 2^MAX_SLOT_BITS slots.
// One word in flight at a time; the result cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module linear_probe_cell_map_unit #(
   parameter int MAX_SLOT_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [lpcm_pkg::KEY_W-1:0]        req_key,
   input  logic [lpcm_pkg::VALUE_W-1:0]      req_value_in,
   input  logic [lpcm_pkg::RECORD_W-1:0]     req_record_in,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [lpcm_pkg::VALUE_W-1:0]      rsp_value_out,
   output logic [lpcm_pkg::RECORD_W-1:0]     rsp_record_out,
   output logic                              rsp_table_full,
   input  logic                              csr_write_en,
   input  logic [lpcm_pkg::TB_W-1:0]         csr_write_data
);
   import lpcm_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   lpcm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   lpcm_dpath #(
      .MAX_SLOT_BITS (MAX_SLOT_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value_in   (req_value_in),
      .req_record_in  (req_record_in),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_value_out  (rsp_value_out),
      .rsp_record_out (rsp_record_out),
      .rsp_table_full (rsp_table_full)
   );

endmodule

FILE: design/lpcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_ctrl: sequencer for the linear probe cell map
// Dispatches actions, walks the probe chain and runs the clearing sweep.
// ----------------------------------------------------------------------------
module lpcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lpcm_pkg::ctl_sts_type sts,
   output lpcm_pkg::ctl_cmd_type cmd
);
   import lpcm_pkg::*;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      owed_ff, owed_in;   // sweep came from a clear action, answer it

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      owed_in  = owed_ff;
      case (state_ff)
         ST_BOOT: begin
            cmd.clr_start = 1'b1;
            owed_in       = 1'b0;
            state_in      = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.clr_write = 1'b1;
            if (sts.sweep_last) begin
               cmd.rsp_fire = owed_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.act)
               ACT_LOOKUP, ACT_INSERT: begin
                  cmd.hash = 1'b1;
                  state_in = ST_READ;
               end
               ACT_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  owed_in       = 1'b1;
                  state_in      = ST_SWEEP;
               end
               default: begin
                  cmd.rsp_fire = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.empty) begin
               cmd.rsp_fire = 1'b1;
               cmd.ins_key  = (sts.act == ACT_INSERT);
               cmd.ins_data = (sts.act == ACT_INSERT);
               state_in     = ST_IDLE;
            end else if (sts.match) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_hit  = 1'b1;
               cmd.ins_data = (sts.act == ACT_INSERT);
               cmd.rsp_data = (sts.act != ACT_INSERT);
               state_in     = ST_IDLE;
            end else if (sts.last_probe) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_full = (sts.act == ACT_INSERT);
               state_in     = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         owed_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         owed_ff  <= owed_in;
      end
   end

endmodule

FILE: design/lpcm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_dpath: slot stores, hash, probe pointer and result registers
// Keys, values and records sit in single-port stores with registered reads.
// ----------------------------------------------------------------------------
module lpcm_dpath #(
   parameter int MAX_SLOT_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_action,
   input  logic [lpcm_pkg::KEY_W-1:0]        req_key,
   input  logic [lpcm_pkg::VALUE_W-1:0]      req_value_in,
   input  logic [lpcm_pkg::RECORD_W-1:0]     req_record_in,
   input  logic                              csr_write_en,
   input  logic [lpcm_pkg::TB_W-1:0]         csr_write_data,
   input  lpcm_pkg::ctl_cmd_type             cmd,
   output lpcm_pkg::ctl_sts_type             sts,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [lpcm_pkg::VALUE_W-1:0]      rsp_value_out,
   output logic [lpcm_pkg::RECORD_W-1:0]     rsp_record_out,
   output logic                              rsp_table_full
);
   import lpcm_pkg::*;

   localparam int AW    = MAX_SLOT_BITS;
   localparam int DEPTH = 1 << AW;
   localparam logic [4:0] MAX_BITS5 = 5'(MAX_SLOT_BITS);
   localparam logic [4:0] MIN_BITS5 = 5'(MIN_SLOT_BITS);

   logic [KEY_W:0]    key_mem [DEPTH];   // bit KEY_W marks a filled slot
   logic [VALUE_W-1:0] val_mem [DEPTH];
   logic [RECORD_W-1:0] rec_mem [DEPTH];

   logic [TB_W-1:0]     table_bits_ff;
   act_type             act_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [RECORD_W-1:0] record_ff;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       count_ff, count_in;
   logic [KEY_W:0]      rd_key_ff;
   logic [VALUE_W-1:0]  rd_val_ff;
   logic [RECORD_W-1:0] rd_rec_ff;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic                rsp_full_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [RECORD_W-1:0] rsp_record_ff;

   logic [4:0]          tb5;
   logic [4:0]          used_bits;
   logic [AW-1:0]       mask;
   logic [2*AW-1:0]     product;
   logic [AW-1:0]       home;

   // slots in use, clamped to the supported range
   always_comb begin
      tb5 = {1'b0, table_bits_ff};
      if (tb5 < MIN_BITS5) begin
         used_bits = MIN_BITS5;
      end else if (tb5 > MAX_BITS5) begin
         used_bits = MAX_BITS5;
      end else begin
         used_bits = tb5;
      end
      for (int i = 0; i < AW; i++) begin
         mask[i] = (5'(i) < used_bits);
      end
   end

   // only the low slot bits of the product matter
   assign product = key_ff[AW-1:0] * HASH_MULT[AW-1:0];
   assign home    = product[AW-1:0] & mask;

   always_comb begin
      addr_in  = addr_ff;
      count_in = count_ff;
      if (cmd.hash) begin
         addr_in  = home;
         count_in = '0;
      end else if (cmd.step) begin
         addr_in  = (addr_ff + 1'b1) & mask;
         count_in = count_ff + 1'b1;
      end else if (cmd.clr_start) begin
         addr_in  = '0;
      end else if (cmd.clr_write) begin
         addr_in  = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_bits_ff <= TB_W'(RESET_TABLE_BITS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            table_bits_ff <= csr_write_data;
         end
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= act_type'(req_action);
         key_ff    <= req_key;
         value_ff  <= req_value_in;
         record_ff <= req_record_in;
      end
      addr_ff  <= addr_in;
      count_ff <= count_in;
      if (cmd.rsp_fire) begin
         rsp_hit_ff    <= cmd.rsp_hit;
         rsp_full_ff   <= cmd.rsp_full;
         rsp_value_ff  <= cmd.rsp_data ? rd_val_ff : '0;
         rsp_record_ff <= cmd.rsp_data ? rd_rec_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         key_mem[addr_ff] <= '0;
      end else if (cmd.ins_key) begin
         key_mem[addr_ff] <= {1'b1, key_ff};
      end
      if (cmd.ins_data) begin
         val_mem[addr_ff] <= value_ff;
         rec_mem[addr_ff] <= record_ff;
      end
      rd_key_ff <= key_mem[addr_ff];
      rd_val_ff <= val_mem[addr_ff];
      rd_rec_ff <= rec_mem[addr_ff];
   end

   assign sts.act        = act_ff;
   assign sts.empty      = ~rd_key_ff[KEY_W];
   assign sts.match      = (rd_key_ff[KEY_W-1:0] == key_ff);
   assign sts.last_probe = (count_ff == mask);
   assign sts.sweep_last = &addr_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_record_out = rsp_record_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

FILE: design/lpcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_checker: port-level checks for the linear probe cell map
// Watches the request and response ports of the top level.
// ----------------------------------------------------------------------------
module lpcm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          rsp_hit,
   input logic [lpcm_pkg::VALUE_W-1:0]  rsp_value_out,
   input logic [lpcm_pkg::RECORD_W-1:0] rsp_record_out,
   input logic                          rsp_table_full
);
   import lpcm_pkg::*;

   // an accepted word raises busy in the cycle after
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted word");

   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without preceding work");

   // hit and full are exclusive
   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_table_full))
      else $error("result flags both hit and full");

   // stored data only returned on a hit
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_value_out == '0 && rsp_record_out == '0))
      else $error("data returned on a miss");

endmodule

bind linear_probe_cell_map_unit lpcm_checker u_lpcm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_value_out  (rsp_value_out),
   .rsp_record_out (rsp_record_out),
   .rsp_table_full (rsp_table_full)
);
